// ===== design/bb3_pkg.sv =====
`default_nettype none
package bb3_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int COL_W    = 11;
    localparam int ROW_W    = 12;
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 13;
    localparam int LS_AW    = $clog2(MAX_WIDTH);
    localparam int LS_DW    = 2 * PIX_W;

    // window sum of nine 8-bit values, then floor(sum/9) by reciprocal
    localparam int SUM_W       = 12;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP       = (1 << RECIP_SHIFT) / 9 + 1;
    localparam int PROD_W      = 24;

    localparam int WIN_N = 9;

    // output queue and pipeline depth between accept and queue push
    localparam int QDEPTH     = 8;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int QCW        = QAW + 1;
    localparam int LAT        = 3;
    localparam int ROOM_LIMIT = QDEPTH - LAT - 1;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_HEIGHT);

    typedef logic [CH_W-1:0] chan_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } meta_t;

    typedef struct packed {
        chan_t            red;
        chan_t            green;
        chan_t            blue;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } result_t;

    typedef struct packed {
        logic valid;
        logic room;
    } queue_status_t;

endpackage
`default_nettype wire

// ===== design/box_blur_3x3_rgb.sv =====
// Pipeline: an accepted item passes the stage 1, stage 2 and stage 3 registers before it is
//   pushed into the output queue; border pixels are consumed and produce no result.
// Throughput: one pixel per clock; each pixel takes one line store read and one write,
//   on separate ports. in_ready drops while the 8-entry output queue holds more than 4.
// Reset (rst_n, asynchronous): counters, pipeline and queue clear; frame size goes
//   to 640x480. Line store contents stay undefined, but unwritten words reach no output.
`default_nettype none
module box_blur_3x3_rgb
    import bb3_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [CH_W-1:0]     in_red,
    input  wire logic [CH_W-1:0]     in_green,
    input  wire logic [CH_W-1:0]     in_blue,

    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [CH_W-1:0]          out_red,
    output logic [CH_W-1:0]          out_green,
    output logic [CH_W-1:0]          out_blue,
    output logic [COL_W-1:0]         out_col,
    output logic [ROW_W-1:0]         out_row,
    output logic                     last_of_frame,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready
);

    // ------------------------------------------------------------------
    // Configuration registers. Values are clamped on write; any write
    // restarts the frame at column 0, row 0.
    // ------------------------------------------------------------------
    logic                cfg_wr;
    logic                reg_sel;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  width_wr;
    logic [HEIGHT_W-1:0] height_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_comb
    begin
        width_wr = pwdata[WIDTH_W-1:0];
        if (width_wr < WIDTH_MIN)
        begin
            width_wr = WIDTH_MIN;
        end
        else if (width_wr > WIDTH_MAX)
        begin
            width_wr = WIDTH_MAX;
        end

        height_wr = pwdata[HEIGHT_W-1:0];
        if (height_wr < HEIGHT_MIN)
        begin
            height_wr = HEIGHT_MIN;
        end
        else if (height_wr > HEIGHT_MAX)
        begin
            height_wr = HEIGHT_MAX;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            if (reg_sel == REG_FRAME_WIDTH)
            begin
                width_reg <= width_wr;
            end
            if (reg_sel == REG_FRAME_HEIGHT)
            begin
                height_reg <= height_wr;
            end
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: raster position of the incoming pixel, and the line
    // store read at its column.
    // ------------------------------------------------------------------
    queue_status_t       q_status;
    logic                accept;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [WIDTH_W-1:0]  col_inc;
    logic [HEIGHT_W-1:0] row_inc;
    logic                emit;
    meta_t               meta_in;

    assign in_ready = q_status.room;
    assign accept   = in_valid && in_ready;

    assign col_inc = WIDTH_W'(col_reg) + WIDTH_W'(1);
    assign row_inc = HEIGHT_W'(row_reg) + HEIGHT_W'(1);

    // An interior pixel is complete once the pixel one right and one down arrives.
    assign emit         = (col_reg >= COL_W'(2)) && (row_reg >= ROW_W'(2));
    assign meta_in.col  = col_reg - COL_W'(1);
    assign meta_in.row  = row_reg - ROW_W'(1);
    assign meta_in.last = (col_inc == width_reg) && (row_inc == height_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= width_reg)
            begin
                col_next = '0;
                if (row_inc >= height_reg)
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_inc[ROW_W-1:0];
                end
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_wr)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1 holds the pixel while the line store read completes.
    logic                s1_valid_reg;
    logic                s1_emit_reg;
    logic [PIX_W-1:0]    s1_pix_reg;
    logic [LS_AW-1:0]    s1_idx_reg;
    meta_t               s1_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg <= emit;
            s1_pix_reg  <= {in_red, in_green, in_blue};
            s1_idx_reg  <= LS_AW'(col_reg);
            s1_meta_reg <= meta_in;
        end
    end

    // Line store word: upper half is two rows up, lower half one row up.
    // Consecutive pixels hit different columns, so the write of stage 1 meets
    // the accept stage's read at one address only after a configuration write.
    logic [LS_DW-1:0] ls_rd;
    logic [PIX_W-1:0] up1;
    logic [PIX_W-1:0] up2;

    assign up1 = ls_rd[PIX_W-1:0];
    assign up2 = ls_rd[LS_DW-1:PIX_W];

    bb3_line_store u_line_store (
        .clk     (clk),
        .rd_addr (LS_AW'(col_reg)),
        .rd_data (ls_rd),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_idx_reg),
        .wr_data ({up1, s1_pix_reg})
    );

    // ------------------------------------------------------------------
    // Stage 2: shift the 3x3 window left and load the new column
    // (two rows up, one row up, current pixel).
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] window_reg  [WIN_N];
    logic [PIX_W-1:0] window_next [WIN_N];
    logic             s2_valid_reg;
    meta_t            s2_meta_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            window_next[k*3+0] = window_reg[k*3+1];
            window_next[k*3+1] = window_reg[k*3+2];
        end
        window_next[2] = up2;
        window_next[5] = up1;
        window_next[8] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_N; k++)
            begin
                window_reg[k] <= '0;
            end
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                for (int k = 0; k < WIN_N; k++)
                begin
                    window_reg[k] <= window_next[k];
                end
            end
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_meta_reg <= s1_meta_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: one lane per color channel sums the nine samples and
    // divides by nine.
    // ------------------------------------------------------------------
    chan_t win_red   [WIN_N];
    chan_t win_green [WIN_N];
    chan_t win_blue  [WIN_N];
    chan_t mean_red;
    chan_t mean_green;
    chan_t mean_blue;

    always_comb
    begin
        for (int k = 0; k < WIN_N; k++)
        begin
            win_red[k]   = window_reg[k][3*CH_W-1:2*CH_W];
            win_green[k] = window_reg[k][2*CH_W-1:CH_W];
            win_blue[k]  = window_reg[k][CH_W-1:0];
        end
    end

    bb3_lane u_lane_red (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (s2_valid_reg),
        .win   (win_red),
        .mean  (mean_red)
    );

    bb3_lane u_lane_green (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (s2_valid_reg),
        .win   (win_green),
        .mean  (mean_green)
    );

    bb3_lane u_lane_blue (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (s2_valid_reg),
        .win   (win_blue),
        .mean  (mean_blue)
    );

    logic  s3_valid_reg;
    meta_t s3_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_meta_reg <= s2_meta_reg;
        end
    end

    // ------------------------------------------------------------------
    // Merge: join the three lane means with the position into one result
    // item and queue it. The queue keeps room for every item in flight.
    // ------------------------------------------------------------------
    result_t merged;
    result_t head;

    assign merged.red   = mean_red;
    assign merged.green = mean_green;
    assign merged.blue  = mean_blue;
    assign merged.col   = s3_meta_reg.col;
    assign merged.row   = s3_meta_reg.row;
    assign merged.last  = s3_meta_reg.last;

    bb3_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_valid_reg),
        .push_data (merged),
        .pop       (out_ready),
        .head      (head),
        .status    (q_status)
    );

    assign out_valid     = q_status.valid;
    assign out_red       = head.red;
    assign out_green     = head.green;
    assign out_blue      = head.blue;
    assign out_col       = head.col;
    assign out_row       = head.row;
    assign last_of_frame = head.last;

endmodule
`default_nettype wire

// ===== design/bb3_line_store.sv =====
`default_nettype none
module bb3_line_store
    import bb3_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [LS_AW-1:0] rd_addr,
    output logic      [LS_DW-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [LS_AW-1:0] wr_addr,
    input  wire logic [LS_DW-1:0] wr_data
);

    logic [LS_DW-1:0] mem [MAX_WIDTH];
    logic [LS_DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== design/bb3_lane.sv =====
`default_nettype none
module bb3_lane
    import bb3_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  wire chan_t win [WIN_N],
    output chan_t      mean
);

    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  sum_reg;
    logic              valid_reg;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  mean_x9;

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < WIN_N; k++)
        begin
            sum_next = sum_next + SUM_W'(win[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load;
        end
    end

    // multiply by the rounded-up reciprocal, exact for every 9-pixel sum
    assign prod    = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign mean    = prod[RECIP_SHIFT +: CH_W];
    assign mean_x9 = SUM_W'(mean) * SUM_W'(9);

    a_mean_floor: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (mean_x9 <= sum_reg) && (sum_reg - mean_x9 < SUM_W'(9)))
        else $error("lane mean is not floor(sum/9)");

endmodule
`default_nettype wire

// ===== design/bb3_out_queue.sv =====
`default_nettype none
module bb3_out_queue
    import bb3_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    input  wire logic    pop,
    output result_t      head,
    output queue_status_t status
);

    result_t          q_mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;
    logic             do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_next;
        end
    end

    assign head         = q_mem_reg[rd_ptr_reg];
    assign status.valid = (count_reg != '0);
    assign status.room  = (count_reg <= QCW'(ROOM_LIMIT));

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < QCW'(QDEPTH)) || do_pop)
        else $error("output queue overflow");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) + QCW'($past(push)) - QCW'($past(do_pop)))
        else $error("output queue count out of step");

endmodule
`default_nettype wire
